// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property that must hold at every clock edge outside reset.
`define CHK_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Implication that must hold outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`endif

// ===== rtl/spinv_pkg.sv =====
package spinv_pkg;

    localparam int CordicSteps = 16;
    localparam logic signed [33:0] CordicGain = 34'sd652032874;
    localparam logic signed [15:0] QuarterTurn = 16'sd16384;

    localparam logic signed [31:0] Sat32Max = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Sat32Min = -32'sh7FFF_FFFF - 32'sd1;

    typedef logic signed [31:0] q16_t;
    typedef logic signed [18:0] trig_t;

    // One input word unpacked.
    typedef struct packed {
        q16_t               pos_x;
        q16_t               pos_y;
        logic signed [15:0] heading;
        q16_t               var_xx;
        q16_t               var_yy;
        q16_t               var_hh;
        q16_t               cov_xy;
        q16_t               cov_xh;
        q16_t               cov_yh;
    } pose_t;

    // One result word unpacked.
    typedef struct packed {
        q16_t               inv_x;
        q16_t               inv_y;
        logic signed [15:0] inv_heading;
        q16_t               out_var_xx;
        q16_t               out_var_yy;
        q16_t               out_var_hh;
        q16_t               out_cov_xy;
        q16_t               out_cov_xh;
        q16_t               out_cov_yh;
        logic               overflow;
    } result_t;

    function automatic logic signed [33:0] atan_turn(input logic [3:0] i);
        logic signed [33:0] r;
        begin
            unique case (i)
                4'd0:  r = 34'sh20000000;
                4'd1:  r = 34'sh12E4051E;
                4'd2:  r = 34'sh09FB385B;
                4'd3:  r = 34'sh051111D4;
                4'd4:  r = 34'sh028B0D43;
                4'd5:  r = 34'sh0145D7E1;
                4'd6:  r = 34'sh00A2F61E;
                4'd7:  r = 34'sh00517C55;
                4'd8:  r = 34'sh0028BE53;
                4'd9:  r = 34'sh00145F2F;
                4'd10: r = 34'sh000A2F98;
                4'd11: r = 34'sh000517CC;
                4'd12: r = 34'sh00028BE6;
                4'd13: r = 34'sh000145F3;
                4'd14: r = 34'sh0000A2FA;
                default: r = 34'sh0000517D;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== rtl/spinv_cordic.sv =====
// Pipelined CORDIC, one rotation per stage, with an enable that freezes all stages.
module spinv_cordic
    import spinv_pkg::*;
(
    input  logic                clk,
    input  logic                en,
    input  logic signed [15:0]  heading,
    output trig_t               cos_q,
    output trig_t               sin_q
);

    logic signed [33:0] x_reg [CordicSteps+1];
    logic signed [33:0] y_reg [CordicSteps+1];
    logic signed [33:0] z_reg [CordicSteps+1];
    logic               fold_reg [CordicSteps+1];
    logic signed [15:0] ang;
    logic               fold;
    logic signed [34:0] xr;
    logic signed [34:0] yr;

    always_comb
    begin
        ang  = heading;
        fold = 1'b0;
        if (heading > QuarterTurn)
        begin
            ang  = heading - 16'sh8000;
            fold = 1'b1;
        end
        else if (heading < -QuarterTurn)
        begin
            ang  = heading + 16'sh8000;
            fold = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= CordicGain;
            y_reg[0]    <= '0;
            z_reg[0]    <= {{2{ang[15]}}, ang, 16'd0};
            fold_reg[0] <= fold;
        end
    end

    for (genvar i = 0; i < CordicSteps; i++)
    begin : g_step
        logic signed [33:0] dx;
        logic signed [33:0] dy;
        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                fold_reg[i+1] <= fold_reg[i];
                if (!z_reg[i][33])
                begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - atan_turn(4'(i));
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + atan_turn(4'(i));
                end
            end
        end
    end

    assign xr = (35'(x_reg[CordicSteps]) + 35'sd8192) >>> 14;
    assign yr = (35'(y_reg[CordicSteps]) + 35'sd8192) >>> 14;
    assign cos_q = fold_reg[CordicSteps] ? -trig_t'(xr) : trig_t'(xr);
    assign sin_q = fold_reg[CordicSteps] ? -trig_t'(yr) : trig_t'(yr);

endmodule

// ===== rtl/spinv_cov.sv =====
// Inverse position and covariance propagation: products registered after each stage.
module spinv_cov
    import spinv_pkg::*;
(
    input  logic    clk,
    input  logic    en,
    input  pose_t   pose,
    input  trig_t   cos_q,
    input  trig_t   sin_q,
    output result_t res
);

    function automatic q16_t sat_q(input logic signed [127:0] v, output logic ov);
        begin
            ov = 1'b0;
            if (v > 128'sd2147483647)
            begin
                ov = 1'b1;
                return Sat32Max;
            end
            if (v < -128'sd2147483648)
            begin
                ov = 1'b1;
                return Sat32Min;
            end
            return q16_t'(v);
        end
    endfunction

    // Stage A: position products.
    pose_t              p_a_reg;
    trig_t              c_a_reg, s_a_reg;
    logic signed [51:0] pxc_reg, pys_reg, pxs_reg, pyc_reg;
    // Stage B: inverse position with saturation.
    pose_t              p_b_reg;
    trig_t              c_b_reg, s_b_reg;
    q16_t               ix_b_reg, iy_b_reg;
    logic               ov_b_reg;
    // Stage C: product terms of M.
    pose_t              p_c_reg;
    trig_t              c_c_reg, s_c_reg;
    q16_t               ix_c_reg, iy_c_reg;
    logic               ov_c_reg;
    logic signed [51:0] t_reg [12];
    logic signed [63:0] ar_reg [3];
    logic signed [63:0] br_reg [3];
    // Stage D: rows of M.
    pose_t              p_d_reg;
    trig_t              c_d_reg, s_d_reg;
    q16_t               ix_d_reg, iy_d_reg;
    logic               ov_d_reg;
    logic signed [65:0] m1_reg [3];
    logic signed [65:0] m2_reg [3];
    // Stage E: partial products of M with H, each entry of M split at bit 32.
    q16_t               ix_e_reg, iy_e_reg, vhh_e_reg;
    logic signed [15:0] hd_e_reg;
    logic               ov_e_reg;
    logic signed [65:0] m12_e_reg, m22_e_reg;
    logic signed [65:0] lo_reg [9];
    logic signed [65:0] hi_reg [9];
    // Stage F: full products of M with H.
    q16_t               ix_f_reg, iy_f_reg, vhh_f_reg;
    logic signed [15:0] hd_f_reg;
    logic               ov_f_reg;
    logic signed [99:0] e_reg [11];

    logic signed [65:0]  mop_w [9];
    logic signed [33:0]  kop_w [9];
    logic signed [127:0] sxx, syy, sxy, sxh, syh;
    logic                o0, o1, o2, o3, o4, o5, o6;
    q16_t                ix_n, iy_n;

    always_comb
    begin
        ix_n = sat_q(128'((-(53'(pxc_reg)) - 53'(pys_reg) + 53'sd32768) >>> 16), o0);
        iy_n = sat_q(128'((53'(pxs_reg) - 53'(pyc_reg) + 53'sd32768) >>> 16), o1);
    end

    // Row one against H1 = (-c, -s, a) and H2 = (s, -c, b), row two against H2.
    // The low half of an entry of M is taken unsigned and the high half signed.
    always_comb
    begin
        mop_w[0] = m1_reg[0];
        kop_w[0] = 34'(c_d_reg);
        mop_w[1] = m1_reg[1];
        kop_w[1] = 34'(s_d_reg);
        mop_w[2] = m1_reg[2];
        kop_w[2] = 34'(iy_d_reg);
        mop_w[3] = m2_reg[0];
        kop_w[3] = 34'(s_d_reg);
        mop_w[4] = m2_reg[1];
        kop_w[4] = 34'(c_d_reg);
        mop_w[5] = m2_reg[2];
        kop_w[5] = -(34'(ix_d_reg));
        mop_w[6] = m1_reg[0];
        kop_w[6] = 34'(s_d_reg);
        mop_w[7] = m1_reg[1];
        kop_w[7] = 34'(c_d_reg);
        mop_w[8] = m1_reg[2];
        kop_w[8] = -(34'(ix_d_reg));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_a_reg <= pose;
            c_a_reg <= cos_q;
            s_a_reg <= sin_q;
            pxc_reg <= pose.pos_x * cos_q;
            pys_reg <= pose.pos_y * sin_q;
            pxs_reg <= pose.pos_x * sin_q;
            pyc_reg <= pose.pos_y * cos_q;

            p_b_reg  <= p_a_reg;
            c_b_reg  <= c_a_reg;
            s_b_reg  <= s_a_reg;
            ix_b_reg <= ix_n;
            iy_b_reg <= iy_n;
            ov_b_reg <= o0 | o1;

            p_c_reg  <= p_b_reg;
            c_c_reg  <= c_b_reg;
            s_c_reg  <= s_b_reg;
            ix_c_reg <= ix_b_reg;
            iy_c_reg <= iy_b_reg;
            ov_c_reg <= ov_b_reg;
            t_reg[0]  <= c_b_reg * p_b_reg.var_xx;
            t_reg[1]  <= s_b_reg * p_b_reg.cov_xy;
            t_reg[2]  <= c_b_reg * p_b_reg.cov_xy;
            t_reg[3]  <= s_b_reg * p_b_reg.var_yy;
            t_reg[4]  <= c_b_reg * p_b_reg.cov_xh;
            t_reg[5]  <= s_b_reg * p_b_reg.cov_yh;
            t_reg[6]  <= s_b_reg * p_b_reg.var_xx;
            t_reg[7]  <= c_b_reg * p_b_reg.cov_xy;
            t_reg[8]  <= s_b_reg * p_b_reg.cov_xy;
            t_reg[9]  <= c_b_reg * p_b_reg.var_yy;
            t_reg[10] <= s_b_reg * p_b_reg.cov_xh;
            t_reg[11] <= c_b_reg * p_b_reg.cov_yh;
            ar_reg[0] <= iy_b_reg * p_b_reg.cov_xh;
            ar_reg[1] <= iy_b_reg * p_b_reg.cov_yh;
            ar_reg[2] <= iy_b_reg * p_b_reg.var_hh;
            br_reg[0] <= -(64'(ix_b_reg) * 64'(p_b_reg.cov_xh));
            br_reg[1] <= -(64'(ix_b_reg) * 64'(p_b_reg.cov_yh));
            br_reg[2] <= -(64'(ix_b_reg) * 64'(p_b_reg.var_hh));

            p_d_reg  <= p_c_reg;
            c_d_reg  <= c_c_reg;
            s_d_reg  <= s_c_reg;
            ix_d_reg <= ix_c_reg;
            iy_d_reg <= iy_c_reg;
            ov_d_reg <= ov_c_reg;
            m1_reg[0] <= -66'(t_reg[0]) - 66'(t_reg[1]) + 66'(ar_reg[0]);
            m1_reg[1] <= -66'(t_reg[2]) - 66'(t_reg[3]) + 66'(ar_reg[1]);
            m1_reg[2] <= -66'(t_reg[4]) - 66'(t_reg[5]) + 66'(ar_reg[2]);
            m2_reg[0] <= 66'(t_reg[6]) - 66'(t_reg[7]) + 66'(br_reg[0]);
            m2_reg[1] <= 66'(t_reg[8]) - 66'(t_reg[9]) + 66'(br_reg[1]);
            m2_reg[2] <= 66'(t_reg[10]) - 66'(t_reg[11]) + 66'(br_reg[2]);

            ix_e_reg  <= ix_d_reg;
            iy_e_reg  <= iy_d_reg;
            vhh_e_reg <= p_d_reg.var_hh;
            hd_e_reg  <= p_d_reg.heading;
            ov_e_reg  <= ov_d_reg;
            m12_e_reg <= m1_reg[2];
            m22_e_reg <= m2_reg[2];
            // Each multiplier is 33 or 34 bits by 34 bits.
            for (int j = 0; j < 9; j++)
            begin
                lo_reg[j] <= 66'($signed({1'b0, mop_w[j][31:0]})) * 66'(kop_w[j]);
                hi_reg[j] <= 66'($signed(mop_w[j][65:32])) * 66'(kop_w[j]);
            end

            ix_f_reg  <= ix_e_reg;
            iy_f_reg  <= iy_e_reg;
            vhh_f_reg <= vhh_e_reg;
            hd_f_reg  <= hd_e_reg;
            ov_f_reg  <= ov_e_reg;
            for (int j = 0; j < 9; j++)
            begin
                e_reg[j] <= (100'(hi_reg[j]) <<< 32) + 100'(lo_reg[j]);
            end
            e_reg[9]  <= 100'(m12_e_reg);
            e_reg[10] <= 100'(m22_e_reg);
        end
    end

    // The heading row of H scales by -1, so those entries are the third column of M.
    always_comb
    begin
        sxx = 128'(-e_reg[0] - e_reg[1]) + (128'(e_reg[2]) <<< 16);
        syy = 128'(e_reg[3] - e_reg[4]) + (128'(e_reg[5]) <<< 16);
        sxy = 128'(e_reg[6] - e_reg[7]) + (128'(e_reg[8]) <<< 16);
        sxh = -(128'(e_reg[9]) <<< 16);
        syh = -(128'(e_reg[10]) <<< 16);
        res.inv_x       = ix_f_reg;
        res.inv_y       = iy_f_reg;
        res.inv_heading = -hd_f_reg;
        res.out_var_xx  = sat_q((sxx + (128'sd1 <<< 31)) >>> 32, o2);
        res.out_var_yy  = sat_q((syy + (128'sd1 <<< 31)) >>> 32, o3);
        res.out_var_hh  = vhh_f_reg;
        res.out_cov_xy  = sat_q((sxy + (128'sd1 <<< 31)) >>> 32, o4);
        res.out_cov_xh  = sat_q((sxh + (128'sd1 <<< 31)) >>> 32, o5);
        res.out_cov_yh  = sat_q((syh + (128'sd1 <<< 31)) >>> 32, o6);
        res.overflow    = ov_f_reg | o2 | o3 | o4 | o5 | o6;
    end

endmodule

// ===== rtl/pose_inverse_with_covariance.sv =====
// Inverts a 2D pose and propagates its 3x3 covariance through the inversion
// Jacobian. The block is a fixed pipeline of 24 register stages: a 17-stage
// CORDIC for sine and cosine, followed by six arithmetic stages and an
// output register. It accepts one word per cycle while the output is not
// stalled, and every word's result leaves through the output register. A
// stall on the output freezes the whole pipeline, so s_axis_tready follows
// the output side directly. Saturation of any 32-bit result sets overflow.
module pose_inverse_with_covariance
    import spinv_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // pos_x, pos_y, heading[15:0], var_xx, var_yy, var_hh, cov_xy, cov_xh, cov_yh
    input  logic [271:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // inv_x, inv_y, inv_heading[15:0], out_var_xx, out_var_yy, out_var_hh,
    // out_cov_xy, out_cov_xh, out_cov_yh
    output logic [271:0] m_axis_tdata,
    // overflow
    output logic         m_axis_tuser
);

    localparam int Depth = CordicSteps + 8;

    pose_t   pose_in;
    pose_t   pose_dly_reg [CordicSteps+1];
    trig_t   cos_q, sin_q;
    result_t res;
    result_t out_reg;
    logic [Depth-1:0] valid_reg;
    logic    en;

    // The pipeline advances whenever the last stage is empty or being taken.
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    assign pose_in.pos_x   = s_axis_tdata[31:0];
    assign pose_in.pos_y   = s_axis_tdata[63:32];
    assign pose_in.heading = s_axis_tdata[79:64];
    assign pose_in.var_xx  = s_axis_tdata[111:80];
    assign pose_in.var_yy  = s_axis_tdata[143:112];
    assign pose_in.var_hh  = s_axis_tdata[175:144];
    assign pose_in.cov_xy  = s_axis_tdata[207:176];
    assign pose_in.cov_xh  = s_axis_tdata[239:208];
    assign pose_in.cov_yh  = s_axis_tdata[271:240];

    spinv_cordic u_cordic
    (
        .clk     (clk),
        .en      (en),
        .heading (pose_in.heading),
        .cos_q   (cos_q),
        .sin_q   (sin_q)
    );

    // Pose fields travel beside the CORDIC so they meet sine and cosine.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pose_dly_reg[0] <= pose_in;
            for (int i = 1; i <= CordicSteps; i++)
            begin
                pose_dly_reg[i] <= pose_dly_reg[i-1];
            end
        end
    end

    spinv_cov u_cov
    (
        .clk   (clk),
        .en    (en),
        .pose  (pose_dly_reg[CordicSteps]),
        .cos_q (cos_q),
        .sin_q (sin_q),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[Depth-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = valid_reg[Depth-1];
    assign m_axis_tdata  = {out_reg.out_cov_yh, out_reg.out_cov_xh, out_reg.out_cov_xy,
                            out_reg.out_var_hh, out_reg.out_var_yy, out_reg.out_var_xx,
                            out_reg.inv_heading, out_reg.inv_y, out_reg.inv_x};
    assign m_axis_tuser  = out_reg.overflow;

endmodule

// ===== rtl/spinv_checker.sv =====
`include "assert_macros.svh"
module spinv_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [271:0] m_axis_tdata,
    input logic         m_axis_tuser
);

    `CHK_IMPLY(a_ready_follows_out, clk, rst_n, m_axis_tvalid && !m_axis_tready, !s_axis_tready, "ready while stalled")
    `CHK_IMPLY(a_idle_ready, clk, rst_n, !m_axis_tvalid, s_axis_tready, "not ready while output empty")
    `CHK_IMPLY(a_hold, clk, rst_n, $past(m_axis_tvalid && !m_axis_tready), m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled word changed")

endmodule

bind pose_inverse_with_covariance spinv_checker u_spinv_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
